[rtl/core/cgl_pkg.sv]
// ---------------------------------------------------------------------------
// cgl_pkg: shared types and constants of the color gradient lookup core
// Field widths, fixed-point constants, operation codes and the stop record.
// ---------------------------------------------------------------------------
`default_nettype none

package cgl_pkg;

    // position format, Q0.FRAC with one extra bit for 1.0
    localparam int POS_FRAC_BITS = 16;
    localparam int POS_W         = POS_FRAC_BITS + 1;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << POS_FRAC_BITS;

    // lookup parameter is signed, one bit wider than a position
    localparam int T_W = POS_W + 1;

    // other field widths
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int COLOR_W = 8;
    localparam int NUM_CH  = 4;

    // product of a position span and a channel difference
    localparam int PROD_W = POS_W + COLOR_W;

    // default table depth
    localparam int MAX_STOPS = 16;

    // operation codes
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // color, red in the low byte
    typedef struct packed {
        logic [COLOR_W-1:0] alpha;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_rgba;

    // one table entry
    typedef struct packed {
        logic [POS_W-1:0] pos;
        t_rgba            color;
    } t_stop;

    localparam int STOP_W = $bits(t_stop);

    // request from the search control to the channel blend lanes
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] span_t;
        logic [POS_W-1:0] span_p;
    } t_lane_req;

endpackage

`default_nettype wire

[rtl/core/cgl_ram.sv]
// ---------------------------------------------------------------------------
// cgl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cgl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/cgl_lane.sv]
// ---------------------------------------------------------------------------
// cgl_lane: one color channel of the linear blend
// Bit-serial shift-and-add multiply, then a restoring divide one quotient
// bit per cycle; result is a + or - the truncated quotient.
// ---------------------------------------------------------------------------
`default_nettype none

module cgl_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cgl_pkg::t_lane_req          i_req,
    input  wire logic [cgl_pkg::COLOR_W-1:0] i_a,
    input  wire logic [cgl_pkg::COLOR_W-1:0] i_b,
    output      logic                        o_done,
    output      logic [cgl_pkg::COLOR_W-1:0] o_color
);

    localparam int CW     = cgl_pkg::COLOR_W;
    localparam int PW     = cgl_pkg::PROD_W;
    localparam int STEPS  = 2 * CW;
    localparam int STEP_W = $clog2(STEPS);

    logic              r_run,   n_run;
    logic              r_done,  n_done;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [CW-1:0]     r_a,     n_a;
    logic              r_neg,   n_neg;
    logic [CW-1:0]     r_mag,   n_mag;
    logic [PW-1:0]     r_mcand, n_mcand;
    logic [PW-1:0]     r_acc,   n_acc;
    logic [PW-1:0]     r_dsh,   n_dsh;
    logic [CW-1:0]     r_quo,   n_quo;
    logic [CW-1:0]     r_color, n_color;

    // multiply phase then divide phase, one bit per cycle
    always_comb begin
        n_run   = r_run;
        n_done  = 1'b0;
        n_step  = r_step;
        n_a     = r_a;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_mcand = r_mcand;
        n_acc   = r_acc;
        n_dsh   = r_dsh;
        n_quo   = r_quo;
        n_color = r_color;
        if (i_req.start) begin
            n_run   = 1'b1;
            n_step  = '0;
            n_a     = i_a;
            n_neg   = (i_b < i_a);
            n_mag   = (i_b < i_a) ? (i_a - i_b) : (i_b - i_a);
            n_mcand = PW'(i_req.span_t);
            n_acc   = '0;
            n_dsh   = PW'(i_req.span_p) << (CW - 1);
            n_quo   = '0;
        end else if (r_run) begin
            if (32'(r_step) < CW) begin
                // shift-and-add over the bits of the channel difference
                if (r_mag[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand = r_mcand << 1;
                n_mag   = r_mag >> 1;
            end else begin
                // restoring divide, quotient does not exceed the channel difference
                if (r_acc >= r_dsh) begin
                    n_acc = r_acc - r_dsh;
                    n_quo = {r_quo[CW-2:0], 1'b1};
                end else begin
                    n_quo = {r_quo[CW-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
            end
            n_step = r_step + 1'b1;
            if (32'(r_step) == STEPS - 1) begin
                n_run   = 1'b0;
                n_done  = 1'b1;
                n_color = r_neg ? (r_a - n_quo) : (r_a + n_quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_a     <= n_a;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_mcand <= n_mcand;
        r_acc   <= n_acc;
        r_dsh   <= n_dsh;
        r_quo   <= n_quo;
        r_color <= n_color;
    end

    assign o_done  = r_done;
    assign o_color = r_color;

endmodule

`default_nettype wire

[rtl/core/color_gradient_lookup_core.sv]
// ---------------------------------------------------------------------------
// color_gradient_lookup_core: piecewise linear RGBA color ramp
// Table of gradient stops searched in order, with a bit-serial channel blend.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. A load (i_operation = load) writes one stop in that cycle and
//   never raises busy; it gives no result. A lookup with stops raises busy
//   until its result is out.
//   Result channel: o_valid is high for one cycle with the color on the
//   o_out_* ports; the receiver cannot stall, the beat is taken that cycle.
//   Config: i_cfg_we writes i_cfg_wdata into the stop count. Users write it only when idle; the core does not check.
// Timing:
//   A lookup with no stops gives its result in the next cycle. Otherwise the
//   stop table memory is read one entry per cycle, the next entry being read
//   while the current one is compared, until an entry at or above t or the
//   last entry ends the search; an interpolation then waits for the blend
//   lanes to multiply and then divide bit-serially. busy falls as the
//   result beat is shown, so the next item can be taken in that cycle.
// Reset:
//   Clears the control state and the stop count; the stop table itself is
//   not cleared and must be loaded before it is used.
// ---------------------------------------------------------------------------
`default_nettype none

module color_gradient_lookup_core #(
    parameter int MAX_STOPS = cgl_pkg::MAX_STOPS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // command channel
    input  wire logic                               start,
    output      logic                               busy,
    input  wire logic                               i_operation,
    input  wire logic [cgl_pkg::IDX_W-1:0]          i_stop_index,
    input  wire logic [cgl_pkg::POS_W-1:0]          i_stop_position,
    input  wire logic [cgl_pkg::COLOR_W-1:0]        i_stop_red,
    input  wire logic [cgl_pkg::COLOR_W-1:0]        i_stop_green,
    input  wire logic [cgl_pkg::COLOR_W-1:0]        i_stop_blue,
    input  wire logic [cgl_pkg::COLOR_W-1:0]        i_stop_alpha,
    input  wire logic signed [cgl_pkg::T_W-1:0]     i_lookup_t,
    // config port
    input  wire logic                               i_cfg_we,
    input  wire logic [cgl_pkg::CNT_W-1:0]          i_cfg_wdata,
    // result channel
    output      logic                               o_valid,
    output      logic [cgl_pkg::COLOR_W-1:0]        o_out_red,
    output      logic [cgl_pkg::COLOR_W-1:0]        o_out_green,
    output      logic [cgl_pkg::COLOR_W-1:0]        o_out_blue,
    output      logic [cgl_pkg::COLOR_W-1:0]        o_out_alpha
);

    localparam int AW  = $clog2(MAX_STOPS);
    localparam int CW  = $clog2(MAX_STOPS + 1);
    localparam int PW  = cgl_pkg::POS_W;
    localparam int IW  = cgl_pkg::IDX_W;
    localparam int CHW = cgl_pkg::COLOR_W;
    localparam int NCH = cgl_pkg::NUM_CH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_BLEND
    } t_state;

    t_state                   r_state, n_state;
    logic [cgl_pkg::CNT_W-1:0] r_count, n_count;
    logic [CW-1:0]            r_cnt,   n_cnt;
    logic [CW-1:0]            r_idx,   n_idx;
    logic [PW-1:0]            r_t,     n_t;
    cgl_pkg::t_stop           r_prev,  n_prev;
    logic                     r_valid, n_valid;
    cgl_pkg::t_rgba           r_color, n_color;

    logic                     accept;
    logic                     load_we;
    logic [AW+IW-1:0]         load_idx_ext;
    logic [PW-1:0]            load_pos;
    cgl_pkg::t_stop           load_stop;
    logic [CW-1:0]            rd_idx;
    logic [cgl_pkg::STOP_W-1:0] ram_rdata;
    cgl_pkg::t_stop           rd_stop;
    logic [CW-1:0]            idx_next;
    logic [CW-1:0]            eff_count;
    logic [PW-1:0]            t_clamped;
    cgl_pkg::t_lane_req       lane_req;
    logic [NCH-1:0]           lane_done;
    logic [NCH-1:0][CHW-1:0]  prev_ch;
    logic [NCH-1:0][CHW-1:0]  cur_ch;
    logic [NCH-1:0][CHW-1:0]  lane_ch;
    cgl_pkg::t_rgba           lane_color;

    assign accept = start && !busy;

    // load path: saturated position, slot range check
    assign load_idx_ext = (AW + IW)'(i_stop_index);
    assign load_we      = accept && (i_operation == cgl_pkg::OP_LOAD)
                          && (32'(i_stop_index) < MAX_STOPS);
    assign load_pos     = (i_stop_position > cgl_pkg::POS_ONE) ?
                          cgl_pkg::POS_ONE : i_stop_position;
    assign load_stop    = '{pos: load_pos,
                            color: '{alpha: i_stop_alpha, blue: i_stop_blue,
                                     green: i_stop_green, red: i_stop_red}};

    // effective count and clamped t at accept
    assign eff_count = (32'(r_count) > MAX_STOPS) ? CW'(MAX_STOPS) : CW'(r_count);
    assign t_clamped = i_lookup_t[cgl_pkg::T_W-1] ? '0 :
                       (i_lookup_t[PW-1:0] > cgl_pkg::POS_ONE) ? cgl_pkg::POS_ONE :
                       i_lookup_t[PW-1:0];

    // read one entry ahead while comparing
    assign idx_next = r_idx + 1'b1;
    assign rd_idx   = (r_state == ST_CMP) ? idx_next : r_idx;

    cgl_ram #(
        .WIDTH (cgl_pkg::STOP_W),
        .DEPTH (MAX_STOPS)
    ) u_stop_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_idx_ext[AW-1:0]),
        .i_wdata (load_stop),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_stop = cgl_pkg::t_stop'(ram_rdata);

    // blend lanes, one per channel
    assign prev_ch           = r_prev.color;
    assign cur_ch            = rd_stop.color;
    assign lane_req.start    = (r_state == ST_CMP) && (rd_stop.pos > r_t)
                               && (r_idx != '0);
    assign lane_req.span_t   = r_t - r_prev.pos;
    assign lane_req.span_p   = rd_stop.pos - r_prev.pos;

    for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
        cgl_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (lane_req),
            .i_a     (prev_ch[ch]),
            .i_b     (cur_ch[ch]),
            .o_done  (lane_done[ch]),
            .o_color (lane_ch[ch])
        );
    end

    assign lane_color = cgl_pkg::t_rgba'(lane_ch);

    // search control
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_t     = r_t;
        n_prev  = r_prev;
        n_valid = 1'b0;
        n_color = r_color;
        if (i_cfg_we) begin
            n_count = i_cfg_wdata;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_operation == cgl_pkg::OP_LOOKUP)) begin
                    if (eff_count == '0) begin
                        n_valid = 1'b1;
                        n_color = '0;
                    end else begin
                        n_state = ST_READ;
                        n_cnt   = eff_count;
                        n_idx   = '0;
                        n_t     = t_clamped;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (rd_stop.pos == r_t) begin
                    // exact match
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    n_color = rd_stop.color;
                end else if (rd_stop.pos > r_t) begin
                    if (r_idx == '0) begin
                        // below the first stop
                        n_state = ST_IDLE;
                        n_valid = 1'b1;
                        n_color = rd_stop.color;
                    end else begin
                        n_state = ST_BLEND;
                    end
                end else begin
                    n_prev = rd_stop;
                    n_idx  = idx_next;
                    if (idx_next == r_cnt) begin
                        // past the last stop
                        n_state = ST_IDLE;
                        n_valid = 1'b1;
                        n_color = rd_stop.color;
                    end
                end
            end
            ST_BLEND: begin
                if (&lane_done) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    n_color = lane_color;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_t     <= n_t;
        r_prev  <= n_prev;
        r_color <= n_color;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_out_red   = r_color.red;
    assign o_out_green = r_color.green;
    assign o_out_blue  = r_color.blue;
    assign o_out_alpha = r_color.alpha;

endmodule

`default_nettype wire

[rtl/core/cgl_checker.sv]
// ---------------------------------------------------------------------------
// cgl_checker: port-level checks of the color gradient lookup core
// Relates command beats, busy and result strobes over time.
// ---------------------------------------------------------------------------
`default_nettype none

module cgl_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            i_operation,
    input wire logic [cgl_pkg::IDX_W-1:0]       i_stop_index,
    input wire logic [cgl_pkg::POS_W-1:0]       i_stop_position,
    input wire logic [cgl_pkg::COLOR_W-1:0]     i_stop_red,
    input wire logic [cgl_pkg::COLOR_W-1:0]     i_stop_green,
    input wire logic [cgl_pkg::COLOR_W-1:0]     i_stop_blue,
    input wire logic [cgl_pkg::COLOR_W-1:0]     i_stop_alpha,
    input wire logic signed [cgl_pkg::T_W-1:0]  i_lookup_t,
    input wire logic                            i_cfg_we,
    input wire logic [cgl_pkg::CNT_W-1:0]       i_cfg_wdata,
    input wire logic                            o_valid,
    input wire logic [cgl_pkg::COLOR_W-1:0]     o_out_red,
    input wire logic [cgl_pkg::COLOR_W-1:0]     o_out_green,
    input wire logic [cgl_pkg::COLOR_W-1:0]     o_out_blue,
    input wire logic [cgl_pkg::COLOR_W-1:0]     o_out_alpha
);

    // a result beat is only shown once the lookup is finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // a lookup beat either starts work or answers at once
    a_lookup_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == cgl_pkg::OP_LOOKUP)) |=> (busy || o_valid))
        else $error("lookup beat neither started nor answered");

    // a load beat gives no result and leaves the core free
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == cgl_pkg::OP_LOAD)) |=> (!busy && !o_valid))
        else $error("load beat produced a result or busy");

    // finishing a lookup always delivers its result
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("lookup finished without a result beat");

endmodule

bind color_gradient_lookup_core cgl_checker u_cgl_checker (.*);

`default_nettype wire
